>>> hw/rtl/refraction_direction_core_assert.svh
// assertion macros used by the checker file
`ifndef REFRACTION_DIRECTION_CORE_ASSERT_SVH
`define REFRACTION_DIRECTION_CORE_ASSERT_SVH

// concurrent check on the rising clock, quiet while reset is high
`define RDIR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// concurrent check that also runs across reset
`define RDIR_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

>>> hw/rtl/rdir_pkg.sv
`timescale 1ns / 1ps

package rdir_pkg;

   // one input item
   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic        [15:0] index_ratio;
   } req_type;

   // one result item
   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_z;
      logic               total_reflect;
   } rsp_type;

   // total register stages from input to result
   localparam int PIPE_DEPTH = 16;

   // reciprocal 2^28 / ratio, four quotient bits per stage
   localparam int RECIP_STAGES = 4;
   localparam int RECIP_STEPS  = 4;
   localparam int RECIP_REM_W  = 29;
   localparam logic [RECIP_REM_W-1:0] RECIP_DIVIDEND = 29'h1000_0000;
   localparam logic [15:0] RATE_MAX    = 16'hFFFF;
   localparam logic [15:0] RECIP_LIMIT = 16'd4096;

   // integer square root, five root bits per stage
   localparam int ISQRT_STAGES = 4;
   localparam int ISQRT_STEPS  = 5;
   localparam int RAD_W        = 40;
   localparam int ROOT_W       = 20;
   localparam int SQ_REM_W     = 24;

   // values riding alongside the square root
   typedef struct packed {
      logic [2:0][15:0] dir;
      logic [2:0][16:0] nrm;
      logic [15:0]      rate;
      logic [19:0]      rc14;
      logic             mirror;
      logic [2:0][15:0] mo;
   } tail_type;

endpackage

>>> hw/rtl/rdir_recip.sv
`timescale 1ns / 1ps

module rdir_recip
   import rdir_pkg::*;
(
   input  logic        clock,
   input  logic [15:0] divisor,
   output logic [15:0] recip
);

   logic [RECIP_REM_W-1:0] rem_ff  [RECIP_STAGES];
   logic [RECIP_REM_W-1:0] rem_in  [RECIP_STAGES];
   logic [15:0]            quo_ff  [RECIP_STAGES];
   logic [15:0]            quo_in  [RECIP_STAGES];
   logic [15:0]            div_ff  [RECIP_STAGES];
   logic [RECIP_REM_W-1:0] src_rem [RECIP_STAGES];
   logic [15:0]            src_quo [RECIP_STAGES];
   logic [15:0]            src_div [RECIP_STAGES];

   // stage sources: the port for the first stage, the previous stage otherwise
   always_comb begin
      src_rem[0] = RECIP_DIVIDEND;
      src_quo[0] = '0;
      src_div[0] = divisor;
      for (int s = 1; s < RECIP_STAGES; s++) begin
         src_rem[s] = rem_ff[s-1];
         src_quo[s] = quo_ff[s-1];
         src_div[s] = div_ff[s-1];
      end
   end

   // restoring division, quotient bits from the top down
   always_comb begin
      logic [RECIP_REM_W-1:0] rem;
      logic [15:0]            quo;
      logic [31:0]            trial;
      for (int s = 0; s < RECIP_STAGES; s++) begin
         rem = src_rem[s];
         quo = src_quo[s];
         for (int j = 0; j < RECIP_STEPS; j++) begin
            trial = {16'd0, src_div[s]} << (15 - s * RECIP_STEPS - j);
            if (32'(rem) >= trial) begin
               rem = rem - trial[RECIP_REM_W-1:0];
               quo = {quo[14:0], 1'b1};
            end else begin
               quo = {quo[14:0], 1'b0};
            end
         end
         rem_in[s] = rem;
         quo_in[s] = quo;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < RECIP_STAGES; s++) begin
         rem_ff[s] <= rem_in[s];
         quo_ff[s] <= quo_in[s];
         div_ff[s] <= src_div[s];
      end
   end

   // small or zero ratios give a quotient past the format, so saturate
   assign recip = (div_ff[RECIP_STAGES-1] <= RECIP_LIMIT) ? RATE_MAX
                                                          : quo_ff[RECIP_STAGES-1];

endmodule

>>> hw/rtl/rdir_isqrt.sv
`timescale 1ns / 1ps

module rdir_isqrt
   import rdir_pkg::*;
(
   input  logic              clock,
   input  logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root
);

   logic [SQ_REM_W-1:0] rem_ff   [ISQRT_STAGES];
   logic [SQ_REM_W-1:0] rem_in   [ISQRT_STAGES];
   logic [ROOT_W-1:0]   root_ff  [ISQRT_STAGES];
   logic [ROOT_W-1:0]   root_in  [ISQRT_STAGES];
   logic [RAD_W-1:0]    rad_ff   [ISQRT_STAGES];
   logic [RAD_W-1:0]    rad_in   [ISQRT_STAGES];
   logic [SQ_REM_W-1:0] src_rem  [ISQRT_STAGES];
   logic [ROOT_W-1:0]   src_root [ISQRT_STAGES];
   logic [RAD_W-1:0]    src_rad  [ISQRT_STAGES];

   // stage sources
   always_comb begin
      src_rem[0]  = '0;
      src_root[0] = '0;
      src_rad[0]  = radicand;
      for (int s = 1; s < ISQRT_STAGES; s++) begin
         src_rem[s]  = rem_ff[s-1];
         src_root[s] = root_ff[s-1];
         src_rad[s]  = rad_ff[s-1];
      end
   end

   // digit-by-digit root, two radicand bits per step
   always_comb begin
      logic [SQ_REM_W-1:0] rem;
      logic [SQ_REM_W-1:0] r4;
      logic [SQ_REM_W-1:0] trial;
      logic [ROOT_W-1:0]   rt;
      logic [RAD_W-1:0]    rad;
      for (int s = 0; s < ISQRT_STAGES; s++) begin
         rem = src_rem[s];
         rt  = src_root[s];
         rad = src_rad[s];
         for (int j = 0; j < ISQRT_STEPS; j++) begin
            r4    = {rem[SQ_REM_W-3:0], rad[RAD_W-1 -: 2]};
            trial = SQ_REM_W'({rt, 2'b01});
            if (r4 >= trial) begin
               rem = r4 - trial;
               rt  = {rt[ROOT_W-2:0], 1'b1};
            end else begin
               rem = r4;
               rt  = {rt[ROOT_W-2:0], 1'b0};
            end
            rad = rad << 2;
         end
         rem_in[s]  = rem;
         root_in[s] = rt;
         rad_in[s]  = rad;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < ISQRT_STAGES; s++) begin
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
         rad_ff[s]  <= rad_in[s];
      end
   end

   assign root = root_ff[ISQRT_STAGES-1];

endmodule

>>> hw/rtl/refraction_direction_core.sv
`timescale 1ns / 1ps
// Refracted ray direction by Snell's law in signed Q2.14, with total
// internal reflection falling back to the mirror direction.
// Input channel: drive req_data and raise start; the item is taken at the
// rising edge where start is high and busy is low. busy stays low, so an
// item may be offered on every cycle.
// Result channel: rsp_valid is high for one cycle with rsp_data; the
// receiver takes it in that cycle and cannot stall the block.
// Throughput: one item per cycle, set by a 16-stage pipeline in which the
// 2^28 / ratio reciprocal takes four stages of four quotient bits each and
// the square root takes four stages of five root bits each.
// Reset clears every stage valid bit; items in flight are dropped and no
// result appears until a new item has gone through.

module refraction_direction_core
   import rdir_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   function automatic logic [15:0] sat16(input logic signed [55:0] v);
      if (v > 56'sd32767) begin
         return 16'h7FFF;
      end else if (v < -56'sd32768) begin
         return 16'h8000;
      end else begin
         return v[15:0];
      end
   endfunction

   // valid bits
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;

   assign busy   = 1'b0;
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   // input lanes
   logic signed [15:0] dir_in [3];
   logic signed [15:0] nrm_in [3];

   assign dir_in[0] = req_data.dir_x;
   assign dir_in[1] = req_data.dir_y;
   assign dir_in[2] = req_data.dir_z;
   assign nrm_in[0] = req_data.normal_x;
   assign nrm_in[1] = req_data.normal_y;
   assign nrm_in[2] = req_data.normal_z;

   // stage registers
   logic signed [15:0] d1_ff [3], d2_ff [3], d3_ff [3], d4_ff [3];
   logic signed [15:0] d5_ff [3], d6_ff [3], d7_ff [3], d8_ff [3];
   logic signed [15:0] n1_ff [3], n2_ff [3];
   logic signed [16:0] nf3_ff [3], nf4_ff [3], nf5_ff [3], nf6_ff [3];
   logic signed [16:0] nf7_ff [3], nf8_ff [3];
   logic [15:0]        r1_ff, r2_ff, r3_ff, r4_ff;
   logic [15:0]        rate5_ff, rate6_ff, rate7_ff, rate8_ff;
   logic signed [31:0] pr1_ff [3], pr1_in [3];
   logic signed [33:0] dot2_ff, dot2_in;
   logic [17:0]        cos3_ff, cos3_in, cos4_ff, cos5_ff;
   logic               flip3_ff, flip3_in, flip4_ff;
   logic signed [16:0] nf3_in [3];
   logic signed [33:0] mh3_ff [3], mh3_in [3];
   logic signed [32:0] ml3_ff [3], ml3_in [3];
   logic [35:0]        cos2_4_ff, cos2_4_in;
   logic signed [50:0] mdn4_ff [3], mdn4_in [3];
   logic [15:0]        rate5_in;
   logic signed [36:0] s28_5_ff, s28_5_in, s28_6_ff;
   logic signed [51:0] v42_5_ff [3], v42_5_in [3];
   logic [31:0]        rsq6_ff, rsq6_in;
   logic [33:0]        rc6_ff, rc6_in;
   logic [15:0]        mo6_ff [3], mo6_in [3], mo7_ff [3], mo8_ff [3];
   logic signed [37:0] ph7_ff, ph7_in;
   logic [35:0]        pl7_ff, pl7_in;
   logic [19:0]        rc14_7_ff, rc14_7_in, rc14_8_ff;
   logic signed [55:0] t42_8_ff, t42_8_in;
   tail_type           tail9_ff, tail9_in;
   logic [RAD_W-1:0]   rad9_ff, rad9_in;
   tail_type           tail_ff [ISQRT_STAGES];
   tail_type           tail14_ff;
   logic signed [21:0] k14_ff, k14_in;
   logic signed [32:0] pr15_ff [3], pr15_in [3];
   logic signed [38:0] pk15_ff [3], pk15_in [3];
   logic               mir15_ff;
   logic [15:0]        mo15_ff [3];
   rsp_type            rsp_ff, rsp_in;

   logic [15:0]        recip_w;
   logic [ROOT_W-1:0]  root_w;

   // reciprocal of the ratio, aligned with stage four
   rdir_recip u_recip (
      .clock   (clock),
      .divisor (req_data.index_ratio),
      .recip   (recip_w)
   );

   // square root of t, from stage nine to stage thirteen
   rdir_isqrt u_isqrt (
      .clock    (clock),
      .radicand (rad9_ff),
      .root     (root_w)
   );

   // stage arithmetic
   always_comb begin
      logic signed [33:0] adot;
      logic signed [33:0] csum;
      logic signed [17:0] dh;
      logic signed [16:0] dl;
      logic [32:0]        rsum;
      logic [17:0]        rr;
      logic signed [18:0] sh;
      logic [17:0]        sl;
      logic [34:0]        rcs;
      logic signed [55:0] tsum;
      logic signed [55:0] t28;
      logic signed [39:0] vsum;
      logic [15:0]        refr [3];

      // products of the dot
      for (int i = 0; i < 3; i++) begin
         pr1_in[i] = dir_in[i] * nrm_in[i];
      end

      // dot sum
      dot2_in = 34'(pr1_ff[0]) + 34'(pr1_ff[1]) + 34'(pr1_ff[2]);

      // flip for a leaving ray, cosine, mirror partial products
      adot     = dot2_ff[33] ? -dot2_ff : dot2_ff;
      csum     = adot + 34'sd8192;
      cos3_in  = csum[31:14];
      flip3_in = (dot2_ff > 34'sd0);
      dh       = $signed(dot2_ff[33:16]);
      dl       = $signed({1'b0, dot2_ff[15:0]});
      for (int i = 0; i < 3; i++) begin
         nf3_in[i] = flip3_in ? -(17'(n2_ff[i])) : 17'(n2_ff[i]);
         mh3_in[i] = dh * n2_ff[i];
         ml3_in[i] = dl * n2_ff[i];
      end

      // cosine squared, dot times normal
      cos2_4_in = cos3_ff * cos3_ff;
      for (int i = 0; i < 3; i++) begin
         mdn4_in[i] = (51'(mh3_ff[i]) <<< 16) + 51'(ml3_ff[i]);
      end

      // ratio select, sine squared, mirror numerator
      rate5_in = flip4_ff ? recip_w : r4_ff;
      s28_5_in = 37'sd268435456 - $signed({1'b0, cos2_4_ff});
      for (int i = 0; i < 3; i++) begin
         v42_5_in[i] = (52'(d4_ff[i]) <<< 28) - (52'(mdn4_ff[i]) <<< 1);
      end

      // ratio squared, ratio times cosine, mirror result
      rsq6_in = rate5_ff * rate5_ff;
      rc6_in  = rate5_ff * cos5_ff;
      for (int i = 0; i < 3; i++) begin
         mo6_in[i] = sat16(56'((v42_5_ff[i] + 52'sd134217728) >>> 28));
      end

      // ratio squared times sine squared, split in two halves
      rsum      = 33'(rsq6_ff) + 33'd8192;
      rr        = rsum[31:14];
      sh        = $signed(s28_6_ff[36:18]);
      sl        = s28_6_ff[17:0];
      ph7_in    = $signed({1'b0, rr}) * sh;
      pl7_in    = rr * sl;
      rcs       = 35'(rc6_ff) + 35'd8192;
      rc14_7_in = rcs[33:14];

      // t in Q.42
      t42_8_in = 56'sd4398046511104 - (56'(ph7_ff) <<< 18) - $signed(56'(pl7_ff));

      // total reflection test, radicand
      tsum    = t42_8_ff + 56'sd8192;
      t28     = tsum >>> 14;
      rad9_in = t42_8_ff[55] ? '0 : t28[RAD_W-1:0];
      tail9_in.rate   = rate8_ff;
      tail9_in.rc14   = rc14_8_ff;
      tail9_in.mirror = t42_8_ff[55];
      for (int i = 0; i < 3; i++) begin
         tail9_in.dir[i] = d8_ff[i];
         tail9_in.nrm[i] = nf8_ff[i];
         tail9_in.mo[i]  = mo8_ff[i];
      end

      // normal weight
      k14_in = $signed({2'b00, tail_ff[ISQRT_STAGES-1].rc14}) - $signed({2'b00, root_w});

      // weighted terms
      for (int i = 0; i < 3; i++) begin
         pr15_in[i] = $signed({1'b0, tail14_ff.rate}) * $signed(tail14_ff.dir[i]);
         pk15_in[i] = k14_ff * $signed(tail14_ff.nrm[i]);
      end

      // final rounding, saturation and branch select
      for (int i = 0; i < 3; i++) begin
         vsum    = 40'(pr15_ff[i]) + 40'(pk15_ff[i]) + 40'sd8192;
         refr[i] = sat16(56'(vsum >>> 14));
      end
      rsp_in.out_x         = mir15_ff ? mo15_ff[0] : refr[0];
      rsp_in.out_y         = mir15_ff ? mo15_ff[1] : refr[1];
      rsp_in.out_z         = mir15_ff ? mo15_ff[2] : refr[2];
      rsp_in.total_reflect = mir15_ff;
   end

   // payload registers
   always_ff @(posedge clock) begin
      r1_ff    <= req_data.index_ratio;
      r2_ff    <= r1_ff;
      r3_ff    <= r2_ff;
      r4_ff    <= r3_ff;
      dot2_ff  <= dot2_in;
      cos3_ff  <= cos3_in;
      cos4_ff  <= cos3_ff;
      cos5_ff  <= cos4_ff;
      flip3_ff <= flip3_in;
      flip4_ff <= flip3_ff;
      cos2_4_ff <= cos2_4_in;
      rate5_ff <= rate5_in;
      rate6_ff <= rate5_ff;
      rate7_ff <= rate6_ff;
      rate8_ff <= rate7_ff;
      s28_5_ff <= s28_5_in;
      s28_6_ff <= s28_5_ff;
      rsq6_ff  <= rsq6_in;
      rc6_ff   <= rc6_in;
      ph7_ff   <= ph7_in;
      pl7_ff   <= pl7_in;
      rc14_7_ff <= rc14_7_in;
      rc14_8_ff <= rc14_7_ff;
      t42_8_ff <= t42_8_in;
      tail9_ff <= tail9_in;
      rad9_ff  <= rad9_in;
      tail_ff[0] <= tail9_ff;
      for (int s = 1; s < ISQRT_STAGES; s++) begin
         tail_ff[s] <= tail_ff[s-1];
      end
      tail14_ff <= tail_ff[ISQRT_STAGES-1];
      k14_ff    <= k14_in;
      mir15_ff  <= tail14_ff.mirror;
      rsp_ff    <= rsp_in;
      for (int i = 0; i < 3; i++) begin
         d1_ff[i]    <= dir_in[i];
         d2_ff[i]    <= d1_ff[i];
         d3_ff[i]    <= d2_ff[i];
         d4_ff[i]    <= d3_ff[i];
         d5_ff[i]    <= d4_ff[i];
         d6_ff[i]    <= d5_ff[i];
         d7_ff[i]    <= d6_ff[i];
         d8_ff[i]    <= d7_ff[i];
         n1_ff[i]    <= nrm_in[i];
         n2_ff[i]    <= n1_ff[i];
         nf3_ff[i]   <= nf3_in[i];
         nf4_ff[i]   <= nf3_ff[i];
         nf5_ff[i]   <= nf4_ff[i];
         nf6_ff[i]   <= nf5_ff[i];
         nf7_ff[i]   <= nf6_ff[i];
         nf8_ff[i]   <= nf7_ff[i];
         pr1_ff[i]   <= pr1_in[i];
         mh3_ff[i]   <= mh3_in[i];
         ml3_ff[i]   <= ml3_in[i];
         mdn4_ff[i]  <= mdn4_in[i];
         v42_5_ff[i] <= v42_5_in[i];
         mo6_ff[i]   <= mo6_in[i];
         mo7_ff[i]   <= mo6_ff[i];
         mo8_ff[i]   <= mo7_ff[i];
         pr15_ff[i]  <= pr15_in[i];
         pk15_ff[i]  <= pk15_in[i];
         mo15_ff[i]  <= tail14_ff.mo[i];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> hw/rtl/rdir_checker.sv
`timescale 1ns / 1ps
`include "refraction_direction_core_assert.svh"

module rdir_checker
   import rdir_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // the pipeline never holds off an item
   `RDIR_ASSERT(a_never_busy, !busy, "busy raised by a stall-free pipeline")

   // every item taken comes out after the fixed latency
   `RDIR_ASSERT(a_item_latency, (start && !busy) |-> ##PIPE_DEPTH rsp_valid, "item lost")

   // no result without an item taken at the matching edge
   `RDIR_ASSERT(a_no_phantom, rsp_valid |-> $past(start && !busy, PIPE_DEPTH), "stray result")

   // reset empties the pipeline
   `RDIR_ASSERT_NR(a_reset_flush, reset |=> !rsp_valid, "result right after reset")

endmodule

bind refraction_direction_core rdir_checker u_rdir_checker (.*);

>>> test/tb_refraction_direction_core.sv
`timescale 1ns / 1ps

module tb_refraction_direction_core;
   import rdir_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   int      fail_count = 0;
   int      idle_pct   = 25;

   refraction_direction_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // one line per mismatch
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // rounding to nearest, halves up
   function automatic longint round_shift(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   function automatic longint int_sqrt(input longint v);
      longint root = 0;
      longint b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   // refracted or mirrored direction for one item
   function automatic rsp_type refract(input req_type q);
      longint  d[3], n[3];
      longint  rate, dot, cos14, s28, rr14, t42, t28, sq14, k14;
      rsp_type r;
      d[0] = longint'(q.dir_x); d[1] = longint'(q.dir_y); d[2] = longint'(q.dir_z);
      n[0] = longint'(q.normal_x); n[1] = longint'(q.normal_y); n[2] = longint'(q.normal_z);
      rate = longint'(q.index_ratio);
      dot = d[0]*n[0] + d[1]*n[1] + d[2]*n[2];
      // ray leaving the surface
      if (dot > 0) begin
         for (int i = 0; i < 3; i++) n[i] = -n[i];
         dot = -dot;
         if (rate == 0) rate = 65535;
         else begin
            rate = (longint'(1) << 28) / rate;
            if (rate > 65535) rate = 65535;
         end
      end
      cos14 = round_shift(-dot, 14);
      s28   = (longint'(1) << 28) - cos14 * cos14;
      rr14  = round_shift(rate * rate, 14);
      t42   = (longint'(1) << 42) - rr14 * s28;
      if (t42 < 0) begin
         r.out_x = clamp16(round_shift(d[0] * (longint'(1) << 28) - 2 * dot * n[0], 28));
         r.out_y = clamp16(round_shift(d[1] * (longint'(1) << 28) - 2 * dot * n[1], 28));
         r.out_z = clamp16(round_shift(d[2] * (longint'(1) << 28) - 2 * dot * n[2], 28));
         r.total_reflect = 1'b1;
      end else begin
         t28  = round_shift(t42, 14);
         sq14 = int_sqrt(t28 < 0 ? 0 : t28);
         k14  = round_shift(rate * cos14, 14) - sq14;
         r.out_x = clamp16(round_shift(rate * d[0] + k14 * n[0], 14));
         r.out_y = clamp16(round_shift(rate * d[1] + k14 * n[1], 14));
         r.out_z = clamp16(round_shift(rate * d[2] + k14 * n[2], 14));
         r.total_reflect = 1'b0;
      end
      return r;
   endfunction

   // expected directions in issue order
   class refraction_scoreboard;
      rsp_type pending_dirs[$];

      function void note_item(input req_type q);
         pending_dirs.push_back(refract(q));
      endfunction

      task check_result(input rsp_type got);
         rsp_type want;
         if (pending_dirs.size() == 0) begin
            report_mismatch("unexpected result", longint'(got.out_x), 0);
            return;
         end
         want = pending_dirs.pop_front();
         if (got.out_x !== want.out_x)
            report_mismatch("out_x", longint'(got.out_x), longint'(want.out_x));
         if (got.out_y !== want.out_y)
            report_mismatch("out_y", longint'(got.out_y), longint'(want.out_y));
         if (got.out_z !== want.out_z)
            report_mismatch("out_z", longint'(got.out_z), longint'(want.out_z));
         if (got.total_reflect !== want.total_reflect)
            report_mismatch("total_reflect", longint'(got.total_reflect),
                            longint'(want.total_reflect));
      endtask
   endclass

   refraction_scoreboard dir_board = new();

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // accepted items and results seen at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) dir_board.note_item(req_data);
         if (rsp_valid) dir_board.check_result(rsp_data);
      end
   end

   // offer one item, with random idle ahead of it, and wait for it to be taken
   task automatic send_item(input req_type q);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // random unit-ish vector component set
   function automatic req_type random_item();
      req_type q;
      int      mode = $urandom_range(9);
      q.dir_x = 16'($urandom()); q.dir_y = 16'($urandom()); q.dir_z = 16'($urandom());
      q.normal_x = 16'($urandom()); q.normal_y = 16'($urandom());
      q.normal_z = 16'($urandom());
      q.index_ratio = 16'($urandom());
      if (mode < 7) begin
         // small components so normalized-looking vectors dominate
         q.dir_x = 16'($signed($urandom_range(16384)) - 8192);
         q.dir_y = 16'($signed($urandom_range(16384)) - 8192);
         q.dir_z = 16'($signed($urandom_range(32768)) - 16384);
         q.normal_x = 16'($signed($urandom_range(16384)) - 8192);
         q.normal_y = 16'($signed($urandom_range(16384)) - 8192);
         q.normal_z = 16'($signed($urandom_range(32768)) - 16384);
         q.index_ratio = 16'($urandom_range(24576, 4096));
      end
      return q;
   endfunction

   function automatic req_type make_item(input int dx, dy, dz, nx, ny, nz, rt);
      req_type q;
      q.dir_x = 16'(dx); q.dir_y = 16'(dy); q.dir_z = 16'(dz);
      q.normal_x = 16'(nx); q.normal_y = 16'(ny); q.normal_z = 16'(nz);
      q.index_ratio = 16'(rt);
      return q;
   endfunction

   // stimulus
   initial begin
      req_type directed[$];
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // entering, leaving, grazing, zero dot, zero and extreme ratios, extremes
      directed.push_back(make_item(0, 0, -16384, 0, 0, 16384, 16384));
      directed.push_back(make_item(8192, 0, -14189, 0, 0, 16384, 12000));
      directed.push_back(make_item(8192, 0, 14189, 0, 0, 16384, 12000));
      directed.push_back(make_item(15000, 0, 6587, 0, 0, 16384, 8192));
      directed.push_back(make_item(16384, 0, 0, 0, 0, 16384, 20000));
      directed.push_back(make_item(0, 0, -16384, 0, 0, 16384, 0));
      directed.push_back(make_item(0, 0, 16384, 0, 0, 16384, 0));
      directed.push_back(make_item(0, 8000, 14000, 0, 0, 16384, 4096));
      directed.push_back(make_item(0, 8000, 14000, 0, 0, 16384, 3000));
      directed.push_back(make_item(14000, 0, -8000, 0, 0, 16384, 65535));
      directed.push_back(make_item(14000, 0, 8000, 0, 0, 16384, 65535));
      directed.push_back(make_item(32767, 32767, 32767, 32767, 32767, 32767, 65535));
      directed.push_back(make_item(-32768, -32768, -32768, 32767, 32767, 32767, 65535));
      directed.push_back(make_item(-32768, -32768, -32768, -32768, -32768, -32768, 4096));
      directed.push_back(make_item(32767, -32768, 0, -32768, 32767, 0, 16384));
      directed.push_back(make_item(0, 0, 0, 0, 0, 0, 16384));
      directed.push_back(make_item(-1, -1, -1, 1, 1, 1, 1));
      foreach (directed[i]) send_item(directed[i]);

      // three idle phases of random items
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 25 : (ph == 1) ? 86 : 0;
         for (int i = 0; i < 410; i++) send_item(random_item());
      end
      start <= 1'b0;

      // drain
      for (int w = 0; w < 2000 && dir_board.pending_dirs.size() != 0; w++)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && dir_board.pending_dirs.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // timeout
   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
